FILE: rtl/core/ted_pkg.sv
// Shared types and constants for the text encoding detector.
package ted_pkg;

  typedef enum logic [1:0] {
    CLASS_ANSI    = 2'd0,
    CLASS_UTF16LE = 2'd1,
    CLASS_UTF8    = 2'd2,
    CLASS_BINARY  = 2'd3
  } enc_class_e;

  // Lead mark kept for each of the last three offsets.
  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_GOOD = 2'd1,
    MARK_FAIL = 2'd2
  } mark_e;

  localparam logic [2:0] PosMax  = 3'd7;
  localparam logic [7:0] BomFf   = 8'hFF;
  localparam logic [7:0] BomFe   = 8'hFE;
  localparam logic [7:0] BomEf   = 8'hEF;
  localparam logic [7:0] BomBb   = 8'hBB;
  localparam logic [7:0] BomBf   = 8'hBF;
  localparam logic [7:0] IllC0   = 8'hC0;
  localparam logic [7:0] IllC1   = 8'hC1;
  localparam logic [7:0] IllF5   = 8'hF5;
  localparam logic [7:0] Lead2Pat = 8'hC0;
  localparam logic [7:0] Lead2Msk = 8'hE0;
  localparam logic [7:0] Lead3Pat = 8'hE0;
  localparam logic [7:0] Lead3Msk = 8'hF0;
  localparam logic [7:0] Lead4Pat = 8'hF0;
  localparam logic [7:0] Lead4Msk = 8'hF8;
  localparam logic [7:0] ContPat  = 8'h80;
  localparam logic [7:0] ContMsk  = 8'hC0;

  typedef struct packed {
    logic [2:0]  pos;
    logic        odd;
    logic [23:0] head;
    logic [7:0]  held;
    logic        zero_word;
    logic        late_zero;
    logic        illegal;
    logic [1:0]  cont;
    mark_e [2:0] win;
    logic        cfail;
    logic        cgood;
    logic        stopped;
  } track_t;

endpackage

FILE: rtl/core/ted_stream_if.sv
// Request channels of the text encoding detector: byte input and class output.
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoding_class;

  modport source (output valid, output encoding_class, input ready);
  modport sink   (input valid, input encoding_class, output ready);
endinterface

FILE: rtl/core/ted_track.sv
// Running-flag update for one byte: head, zero tests, illegal bytes, UTF-8 scan.
module ted_track (
  input  ted_pkg::track_t cur_i,
  input  logic [7:0]      data_byte_i,
  output ted_pkg::track_t nxt_o
);

  ted_pkg::mark_e mark;
  logic           found;

  always_comb begin
    nxt_o = cur_i;
    mark  = ted_pkg::MARK_NONE;
    found = 1'b0;

    if (!cur_i.odd) begin
      nxt_o.held = data_byte_i;
    end else if (cur_i.held == 8'h00 && data_byte_i == 8'h00) begin
      nxt_o.zero_word = 1'b1;
    end
    if (cur_i.pos >= 3'd2 && data_byte_i == 8'h00) begin
      nxt_o.late_zero = 1'b1;
    end

    case (cur_i.pos)
      3'd0:    nxt_o.head[7:0]   = data_byte_i;
      3'd1:    nxt_o.head[15:8]  = data_byte_i;
      3'd2:    nxt_o.head[23:16] = data_byte_i;
      default: ;
    endcase

    if (data_byte_i == ted_pkg::IllC0 || data_byte_i == ted_pkg::IllC1 ||
        data_byte_i >= ted_pkg::IllF5) begin
      nxt_o.illegal = 1'b1;
    end

    // UTF-8 scan
    if (!cur_i.stopped) begin
      if (cur_i.cont != 2'd0) begin
        if ((data_byte_i & ted_pkg::ContMsk) != ted_pkg::ContPat) begin
          // bad continuation: fail the newest open lead, stop scanning
          for (int k = 0; k < 3; k++) begin
            if (!found && nxt_o.win[k] != ted_pkg::MARK_NONE) begin
              nxt_o.win[k] = ted_pkg::MARK_FAIL;
              found        = 1'b1;
            end
          end
          nxt_o.stopped = 1'b1;
          nxt_o.cont    = 2'd0;
        end else begin
          nxt_o.cont = cur_i.cont - 2'd1;
        end
      end else if ((data_byte_i & ted_pkg::Lead2Msk) == ted_pkg::Lead2Pat) begin
        mark       = ted_pkg::MARK_GOOD;
        nxt_o.cont = 2'd1;
      end else if ((data_byte_i & ted_pkg::Lead3Msk) == ted_pkg::Lead3Pat) begin
        mark       = ted_pkg::MARK_GOOD;
        nxt_o.cont = 2'd2;
      end else if ((data_byte_i & ted_pkg::Lead4Msk) == ted_pkg::Lead4Pat) begin
        mark       = ted_pkg::MARK_GOOD;
        nxt_o.cont = 2'd3;
      end
    end

    // lead three places back is now judged
    if (nxt_o.win[2] == ted_pkg::MARK_GOOD) begin
      nxt_o.cgood = 1'b1;
    end else if (nxt_o.win[2] == ted_pkg::MARK_FAIL) begin
      nxt_o.cfail = 1'b1;
    end
    nxt_o.win[2] = nxt_o.win[1];
    nxt_o.win[1] = nxt_o.win[0];
    nxt_o.win[0] = mark;

    nxt_o.odd = ~cur_i.odd;
    if (cur_i.pos < ted_pkg::PosMax) begin
      nxt_o.pos = cur_i.pos + 3'd1;
    end
  end

endmodule

FILE: rtl/core/ted_decide.sv
// Priority decision of the encoding class from the final running flags.
module ted_decide (
  input  ted_pkg::track_t    st_i,
  output ted_pkg::enc_class_e cls_o
);

  logic [7:0] b0, b1, b2;

  assign b0 = st_i.head[7:0];
  assign b1 = st_i.head[15:8];
  assign b2 = st_i.head[23:16];

  always_comb begin
    if (st_i.pos < 3'd2) begin
      cls_o = ted_pkg::CLASS_ANSI;
    end else if (st_i.zero_word) begin
      cls_o = ted_pkg::CLASS_BINARY;
    end else if (st_i.late_zero && !st_i.odd) begin
      cls_o = ted_pkg::CLASS_UTF16LE;
    end else if (b0 == ted_pkg::BomFf && b1 == ted_pkg::BomFe) begin
      cls_o = ted_pkg::CLASS_UTF16LE;
    end else if (st_i.pos < 3'd3) begin
      cls_o = ted_pkg::CLASS_ANSI;
    end else if (b0 == ted_pkg::BomEf && b1 == ted_pkg::BomBb && b2 == ted_pkg::BomBf) begin
      cls_o = ted_pkg::CLASS_UTF8;
    end else if (st_i.illegal || st_i.cfail) begin
      cls_o = ted_pkg::CLASS_ANSI;
    end else if (st_i.cgood) begin
      cls_o = ted_pkg::CLASS_UTF8;
    end else begin
      cls_o = ted_pkg::CLASS_ANSI;
    end
  end

endmodule

FILE: rtl/core/text_encoding_detector.sv
// Top level of the text encoding detector: input register, flag update, result register.
//
// Usage
//   in_i  (sink): one byte per request, data_byte plus last_byte on the final
//                 byte of a buffer. Bytes of one buffer follow each other.
//   out_o (source): one request per buffer carrying encoding_class
//                 (0 ANSI, 1 UTF-16LE, 2 UTF-8, 3 binary), none for other bytes.
// Throughput: one byte per cycle, across buffer boundaries too, but for the stall below.
//   The per-byte flag update is a single short combinational step between the
//   input register and the running-state register, so nothing iterates.
// Path: a final byte goes from the input register through the decision into the
//   result register, which drives out_o.valid; a busy result register holds it back.
// Stall: the result register is a one-deep output stage. While it holds an
//   untaken class, non-final bytes keep flowing; a further final byte waits
//   in the input register, and in_i.ready drops only then.
// Reset: rst_ni low clears the running state and both valid flags; the first
//   byte after reset opens a new buffer. State also returns to zero after
//   each final byte.
module text_encoding_detector (
  input  logic      clk_i,
  input  logic      rst_ni,
  ted_in_if.sink    in_i,
  ted_out_if.source out_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // running state of the current buffer
  ted_pkg::track_t state_q, state_d;

  // result register
  logic                 out_valid_q;
  ted_pkg::enc_class_e  out_class_q;
  ted_pkg::enc_class_e  class_d;

  logic out_free, s1_fire, in_ready, in_take;

  assign out_free = !out_valid_q || out_o.ready;
  // a non-final byte never needs the output stage
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_fire;
  assign in_take  = in_i.valid && in_ready;

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.encoding_class = out_class_q;

  ted_track u_track (
    .cur_i      (state_q),
    .data_byte_i(s1_byte_q),
    .nxt_o      (state_d)
  );

  // decision sees the state including the final byte itself
  ted_decide u_decide (
    .st_i (state_d),
    .cls_o(class_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        state_q <= s1_last_q ? '0 : state_d;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (s1_fire && s1_last_q) begin
      out_class_q <= class_d;
    end
  end

`ifndef SYNTH
  // a final byte clears the buffer state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (state_q.pos == 3'd0 && !state_q.odd))
    else $error("state not cleared after final byte");

  // no byte seen means even parity
  a_pos_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pos == 3'd0) |-> !state_q.odd)
    else $error("odd parity with empty buffer");

  // a stopped scan owes no continuation bytes
  a_stop_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stopped |-> (state_q.cont == 2'd0))
    else $error("continuations pending after scan stop");

  // a blocked final byte holds off further input
  a_block_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while final byte blocked");
`endif

endmodule

FILE: tb/text_encoding_detector_tb.sv
// Self-checking bench for the text encoding detector: directed buffers, then random text.
module text_encoding_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. Bytes past CalmFrom go in with no idling on either side.
  localparam int unsigned ByteTarget    = 1450;
  localparam int unsigned CalmFrom      = 1250;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned DrainCycles   = 4;

  // One row of the directed table. Where pinned is set the class is typed in
  // by hand; otherwise the class tracker decides what to expect.
  typedef struct packed {
    logic [7:0]          data;
    logic                last;
    logic                pinned;
    ted_pkg::enc_class_e cls;
  } stim_row_t;

  // Flavours of random buffer.
  typedef enum logic [3:0] {
    KIND_NOISE,
    KIND_ASCII,
    KIND_UTF8,
    KIND_UTF8_BROKEN,
    KIND_UTF16,
    KIND_BOM8,
    KIND_BINARY,
    KIND_ILLEGAL,
    KIND_TINY
  } text_kind_e;

  localparam stim_row_t DirectedRows [24] = '{
    // single-byte buffer
    '{8'h41,          1'b1, 1'b1, ted_pkg::CLASS_ANSI},
    // aligned zero word
    '{8'h00,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h00,          1'b1, 1'b1, ted_pkg::CLASS_BINARY},
    // FF FE mark, also the largest byte value
    '{ted_pkg::BomFf, 1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{ted_pkg::BomFe, 1'b1, 1'b1, ted_pkg::CLASS_UTF16LE},
    // EF BB BF mark
    '{ted_pkg::BomEf, 1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{ted_pkg::BomBb, 1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{ted_pkg::BomBf, 1'b1, 1'b1, ted_pkg::CLASS_UTF8},
    // late zero bytes in an even-length buffer
    '{8'h41,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h00,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h42,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h00,          1'b1, 1'b0, ted_pkg::CLASS_ANSI},
    // illegal byte
    '{8'h41,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{ted_pkg::IllC0, 1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h42,          1'b1, 1'b1, ted_pkg::CLASS_ANSI},
    // three-byte sequence whose lead gets judged
    '{8'hE2,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h82,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'hAC,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h41,          1'b1, 1'b0, ted_pkg::CLASS_ANSI},
    // odd trailing byte is not paired into a word
    '{8'h41,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h00,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h00,          1'b1, 1'b0, ted_pkg::CLASS_ANSI},
    // two-byte buffer, no mark
    '{8'h41,          1'b0, 1'b0, ted_pkg::CLASS_ANSI},
    '{8'h42,          1'b1, 1'b1, ted_pkg::CLASS_ANSI}
  };

  // Bytes that make short buffers interesting.
  localparam logic [7:0] TinyPick [8] = '{8'h00, ted_pkg::BomFf, ted_pkg::BomFe,
                                          ted_pkg::BomEf, ted_pkg::BomBb, ted_pkg::BomBf,
                                          8'h41, ted_pkg::ContPat};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ted_in_if  in_if ();
  ted_out_if out_if ();

  text_encoding_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Class tracker: mirrors the running flags of the block, one byte at a time.
  logic [2:0]      pos_cnt;
  logic            odd_len;
  logic [23:0]     head;
  logic [7:0]      held_even;
  logic            zero_word;
  logic            late_zero;
  logic            illegal_seen;
  logic [1:0]      cont_left;
  ted_pkg::mark_e  lead_win [3];
  logic            judged_fail;
  logic            judged_good;
  logic            scan_halt;

  // Classes still owed by the block, oldest first.
  ted_pkg::enc_class_e class_q [$];

  // Side information travelling with the byte on offer.
  logic                in_pinned;
  ted_pkg::enc_class_e in_pinned_cls;

  logic [7:0]  text_q [$];
  int unsigned bytes_sent   = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  ted_pkg::enc_class_e predicted;
  ted_pkg::enc_class_e wanted;

  function automatic void clear_tracker();
    pos_cnt      = '0;
    odd_len      = 1'b0;
    head         = '0;
    held_even    = '0;
    zero_word    = 1'b0;
    late_zero    = 1'b0;
    illegal_seen = 1'b0;
    cont_left    = '0;
    foreach (lead_win[k]) lead_win[k] = ted_pkg::MARK_NONE;
    judged_fail  = 1'b0;
    judged_good  = 1'b0;
    scan_halt    = 1'b0;
  endfunction

  // Feeds one byte to the tracker. Returns 1 with the class on a final byte.
  function automatic bit track_byte(input logic [7:0] b, input logic lst,
                                    output ted_pkg::enc_class_e cls);
    ted_pkg::mark_e mark;
    bit             blamed;
    mark   = ted_pkg::MARK_NONE;
    blamed = 1'b0;
    cls    = ted_pkg::CLASS_ANSI;

    // word pairing for the binary test
    if (!odd_len) begin
      held_even = b;
    end else if (held_even == 8'h00 && b == 8'h00) begin
      zero_word = 1'b1;
    end
    if (pos_cnt >= 3'd2 && b == 8'h00) late_zero = 1'b1;
    if (pos_cnt < 3'd3) head[8*pos_cnt +: 8] = b;
    if (b == ted_pkg::IllC0 || b == ted_pkg::IllC1 || b >= ted_pkg::IllF5)
      illegal_seen = 1'b1;

    // UTF-8 lead scan; a bad continuation blames the newest open lead
    if (!scan_halt) begin
      if (cont_left != 2'd0) begin
        if ((b & ted_pkg::ContMsk) != ted_pkg::ContPat) begin
          for (int k = 0; k < 3; k++) begin
            if (!blamed && lead_win[k] != ted_pkg::MARK_NONE) begin
              lead_win[k] = ted_pkg::MARK_FAIL;
              blamed      = 1'b1;
            end
          end
          scan_halt = 1'b1;
          cont_left = 2'd0;
        end else begin
          cont_left = cont_left - 2'd1;
        end
      end else if ((b & ted_pkg::Lead2Msk) == ted_pkg::Lead2Pat) begin
        mark      = ted_pkg::MARK_GOOD;
        cont_left = 2'd1;
      end else if ((b & ted_pkg::Lead3Msk) == ted_pkg::Lead3Pat) begin
        mark      = ted_pkg::MARK_GOOD;
        cont_left = 2'd2;
      end else if ((b & ted_pkg::Lead4Msk) == ted_pkg::Lead4Pat) begin
        mark      = ted_pkg::MARK_GOOD;
        cont_left = 2'd3;
      end
    end
    // the lead three offsets back now has its byte three on, so it counts
    if (lead_win[2] == ted_pkg::MARK_GOOD) begin
      judged_good = 1'b1;
    end else if (lead_win[2] == ted_pkg::MARK_FAIL) begin
      judged_fail = 1'b1;
    end
    lead_win[2] = lead_win[1];
    lead_win[1] = lead_win[0];
    lead_win[0] = mark;

    odd_len = ~odd_len;
    if (pos_cnt < ted_pkg::PosMax) pos_cnt = pos_cnt + 3'd1;

    if (!lst) return 1'b0;

    // priority order of the rules
    if (pos_cnt < 3'd2) cls = ted_pkg::CLASS_ANSI;
    else if (zero_word) cls = ted_pkg::CLASS_BINARY;
    else if (late_zero && !odd_len) cls = ted_pkg::CLASS_UTF16LE;
    else if (head[7:0] == ted_pkg::BomFf && head[15:8] == ted_pkg::BomFe)
      cls = ted_pkg::CLASS_UTF16LE;
    else if (pos_cnt < 3'd3) cls = ted_pkg::CLASS_ANSI;
    else if (head == {ted_pkg::BomBf, ted_pkg::BomBb, ted_pkg::BomEf})
      cls = ted_pkg::CLASS_UTF8;
    else if (illegal_seen) cls = ted_pkg::CLASS_ANSI;
    else if (judged_fail) cls = ted_pkg::CLASS_ANSI;
    else if (judged_good) cls = ted_pkg::CLASS_UTF8;
    else cls = ted_pkg::CLASS_ANSI;
    clear_tracker();
    return 1'b1;
  endfunction

  // Appends one character of UTF-8 text; may_break spoils continuations now and then.
  function automatic void push_utf8_char(input bit may_break);
    int unsigned nbytes;
    logic [7:0]  lead;
    nbytes = $urandom_range(1, 4);
    case (nbytes)
      1:       lead = 8'($urandom_range(8'h20, 8'h7E));
      2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
      3:       lead = ted_pkg::Lead3Pat | 8'($urandom_range(0, 15));
      default: lead = ted_pkg::Lead4Pat | 8'($urandom_range(0, 4));
    endcase
    text_q = {text_q, lead};
    for (int k = 1; k < nbytes; k++) begin
      if (may_break && $urandom_range(0, 5) == 0) begin
        // plain letter or a fresh lead where a continuation belongs
        text_q = {text_q, $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E))
                                               : 8'($urandom_range(8'hC2, 8'hEF))};
      end else begin
        text_q = {text_q, ted_pkg::ContPat | 8'($urandom_range(0, 63))};
      end
    end
  endfunction

  // Fills text_q with one random buffer, mostly well-formed text of some kind.
  function automatic void build_text();
    int unsigned r;
    int unsigned n;
    int unsigned at;
    logic [7:0]  bad;
    text_kind_e  kind;
    text_q.delete();
    r = $urandom_range(0, 15);
    // mostly short buffers, a few long ones; any of 7 bytes or more saturates the position count
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    case (r)
      0, 1:       kind = KIND_NOISE;
      2, 3:       kind = KIND_ASCII;
      4, 5, 6, 7: kind = KIND_UTF8;
      8, 9:       kind = KIND_UTF8_BROKEN;
      10, 11:     kind = KIND_UTF16;
      12:         kind = KIND_BOM8;
      13:         kind = KIND_BINARY;
      14:         kind = KIND_ILLEGAL;
      default:    kind = KIND_TINY;
    endcase
    case (kind)
      KIND_NOISE: repeat (n) text_q = {text_q, 8'($urandom)};
      KIND_ASCII: repeat (n) text_q = {text_q, 8'($urandom_range(8'h20, 8'h7E))};
      KIND_UTF8, KIND_UTF8_BROKEN, KIND_ILLEGAL: begin
        if (kind == KIND_UTF8 && $urandom_range(0, 3) == 0) begin
          text_q = {text_q, ted_pkg::BomEf, ted_pkg::BomBb, ted_pkg::BomBf};
        end
        while (text_q.size() < n) push_utf8_char(kind == KIND_UTF8_BROKEN);
        // cut mid-character now and then, so the tail lead is never judged
        if ($urandom_range(0, 2) == 0) begin
          while (text_q.size() > n) void'(text_q.pop_back());
        end
        if (kind == KIND_ILLEGAL) begin
          case ($urandom_range(0, 2))
            0:       bad = ted_pkg::IllC0;
            1:       bad = ted_pkg::IllC1;
            default: bad = 8'($urandom_range(ted_pkg::IllF5, 8'hFF));
          endcase
          at = $urandom_range(0, text_q.size());
          text_q.insert(at, bad);
        end
      end
      KIND_UTF16: begin
        if ($urandom_range(0, 1)) begin
          text_q = {text_q, ted_pkg::BomFf, ted_pkg::BomFe};
        end
        repeat (n) begin
          if ($urandom_range(0, 3) != 0) begin
            text_q = {text_q, 8'($urandom_range(8'h20, 8'h7E)), 8'h00};
          end else begin
            text_q = {text_q, 8'($urandom), 8'($urandom_range(8'h01, 8'hFF))};
          end
        end
        // odd length now and then: late zeros no longer count
        if ($urandom_range(0, 4) == 0) void'(text_q.pop_back());
      end
      KIND_BOM8: begin
        text_q = {text_q, ted_pkg::BomEf, ted_pkg::BomBb, ted_pkg::BomBf};
        repeat (n) text_q = {text_q, 8'($urandom)};
      end
      KIND_BINARY: begin
        repeat (n) text_q = {text_q, 8'($urandom)};
        // zero pair at any offset, aligned or not
        at = $urandom_range(0, text_q.size());
        text_q.insert(at, 8'h00);
        text_q.insert(at, 8'h00);
      end
      default: begin
        repeat ($urandom_range(1, 3)) text_q = {text_q, TinyPick[$urandom_range(0, 7)]};
      end
    endcase
  endfunction

  // Offers one byte on the input channel and returns at the falling edge after
  // the request is taken. Called at a falling edge.
  task automatic offer_byte(input logic [7:0] b, input logic lst, input logic pinned,
                            input ted_pkg::enc_class_e cls);
    if (bytes_sent < CalmFrom && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= lst;
    in_pinned       <= pinned;
    in_pinned_cls   <= cls;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Sender: reset, directed table, then random buffers until the byte budget is spent.
  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    in_pinned       = 1'b0;
    in_pinned_cls   = ted_pkg::CLASS_ANSI;
    clear_tracker();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i]) begin
      offer_byte(DirectedRows[i].data, DirectedRows[i].last, DirectedRows[i].pinned,
                 DirectedRows[i].cls);
    end

    while (bytes_sent < ByteTarget) begin
      build_text();
      foreach (text_q[i]) begin
        offer_byte(text_q[i], i == text_q.size() - 1, 1'b0, ted_pkg::CLASS_ANSI);
      end
    end
    in_if.valid <= 1'b0;

    // drain: every class owed has come back, then a further wait for strays
    while (class_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, and one long hold-off early in the random part so
  // that the result stage fills and the next final byte backs up the input.
  initial begin : receiver
    bit held_off;
    held_off     = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_taken >= 12) begin
        held_off     = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (bytes_sent < CalmFrom && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: result requests are checked before the byte of the same edge is
  // tracked, so a stray result can never match a class owed by that byte.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        results_taken++;
        if (class_q.size() == 0) begin
          $error("encoding_class: unexpected result, actual %0d", out_if.encoding_class);
          fail_count++;
        end else begin
          wanted = class_q.pop_front();
          if (out_if.encoding_class !== wanted) begin
            $error("encoding_class mismatch: expected %0d, actual %0d", wanted,
                   out_if.encoding_class);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        quiet_cycles = 0;
        if (track_byte(in_if.data_byte, in_if.last_byte, predicted)) begin
          if (in_pinned) begin
            class_q = {class_q, in_pinned_cls};
          end else begin
            class_q = {class_q, predicted};
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $error("no request moved for %0d cycles, %0d classes owed", quiet_cycles,
               class_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
rtl/core/ted_pkg.sv
rtl/core/ted_stream_if.sv
rtl/core/ted_track.sv
rtl/core/ted_decide.sv
rtl/core/text_encoding_detector.sv
tb/text_encoding_detector_tb.sv
